// ----- hdl/rvn_pkg.sv -----
// rvn_pkg: widths and stage counts for the RGB vector normalizer.
// No dependencies; imported by rgb_vector_normalizer_unit.
`default_nettype none
package rvn_pkg;
  localparam int OUT_FRACTION_BITS = 15;
  localparam int COMP_W   = 16;
  localparam int SQ_W     = 2 * COMP_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int TGT_W    = SQ_W + 2 * OUT_FRACTION_BITS;
  localparam int WIDE_W   = SUM_W + 2 * (OUT_FRACTION_BITS + 1);
  localparam int Q_BITS   = OUT_FRACTION_BITS + 1;
  localparam int LANES    = 3;
  localparam int NUM_STAGES = Q_BITS + 2;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [Q_BITS-1:0] quot_t;
endpackage
`default_nettype wire

// ----- hdl/rgb_vector_normalizer_unit.sv -----
// Pipelined normalizer: scales an unsigned Q4.12 RGB vector to unit length, Q1.15 out.
// Depends on rvn_pkg.
//
// One word per clock enters and leaves when the output side keeps ready high. One stage
// squares, one sums, then one stage per quotient bit of a restoring search that tracks
// q*q*S and q*S with shifts and adds only. Every stage holds its own valid bit, so a stall
// at the output fills bubbles before it blocks the input. An all-zero vector gives zero
// components and raises zero_length.
`default_nettype none
module rgb_vector_normalizer_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire rvn_pkg::comp_t red_in,
  input  wire rvn_pkg::comp_t green_in,
  input  wire rvn_pkg::comp_t blue_in,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      rvn_pkg::comp_t red_unit,
  output      rvn_pkg::comp_t green_unit,
  output      rvn_pkg::comp_t blue_unit,
  output      logic          zero_length
);
  import rvn_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  logic [SQ_W-1:0]  sq   [LANES];
  logic [SUM_W-1:0] s    [NUM_STAGES];
  logic             zr   [NUM_STAGES];
  wide_t            tgt  [NUM_STAGES][LANES];
  wide_t            pp   [NUM_STAGES][LANES];
  wide_t            qs   [NUM_STAGES][LANES];
  quot_t            qv   [NUM_STAGES][LANES];

  wide_t cand [Q_BITS][LANES];
  wide_t sk   [Q_BITS];
  logic  take [Q_BITS][LANES];

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end
  assign in_ready = en[0];

  // bit stage b decides quotient bit k = Q_BITS-1-b, reading stage b+1
  always_comb begin
    for (int b = 0; b < Q_BITS; b++) begin
      sk[b] = WIDE_W'(s[b+1]) << (2 * (Q_BITS - 1 - b));
      for (int l = 0; l < LANES; l++) begin
        cand[b][l] = pp[b+1][l] + (qs[b+1][l] << (Q_BITS - b)) + sk[b];
        take[b][l] = cand[b][l] <= tgt[b+1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq[0]  <= SQ_W'(red_in) * SQ_W'(red_in);
      sq[1]  <= SQ_W'(green_in) * SQ_W'(green_in);
      sq[2]  <= SQ_W'(blue_in) * SQ_W'(blue_in);
      zr[0]  <= (red_in == '0) && (green_in == '0) && (blue_in == '0);
    end
    if (en[1]) begin
      s[1]  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      zr[1] <= zr[0];
      for (int l = 0; l < LANES; l++) begin
        tgt[1][l] <= WIDE_W'(sq[l]) << (2 * OUT_FRACTION_BITS);
        pp[1][l]  <= '0;
        qs[1][l]  <= '0;
        qv[1][l]  <= '0;
      end
    end
    for (int b = 0; b < Q_BITS; b++) begin
      if (en[b+2]) begin
        s[b+2]  <= s[b+1];
        zr[b+2] <= zr[b+1];
        for (int l = 0; l < LANES; l++) begin
          tgt[b+2][l] <= tgt[b+1][l];
          if (take[b][l]) begin
            pp[b+2][l] <= cand[b][l];
            qs[b+2][l] <= qs[b+1][l] + (WIDE_W'(s[b+1]) << (Q_BITS - 1 - b));
            qv[b+2][l] <= qv[b+1][l] | (quot_t'(1) << (Q_BITS - 1 - b));
          end else begin
            pp[b+2][l] <= pp[b+1][l];
            qs[b+2][l] <= qs[b+1][l];
            qv[b+2][l] <= qv[b+1][l];
          end
        end
      end
    end
  end

  assign out_valid   = vld[NUM_STAGES-1];
  assign zero_length = zr[NUM_STAGES-1];
  assign red_unit    = zr[NUM_STAGES-1] ? '0 : COMP_W'(qv[NUM_STAGES-1][0]);
  assign green_unit  = zr[NUM_STAGES-1] ? '0 : COMP_W'(qv[NUM_STAGES-1][1]);
  assign blue_unit   = zr[NUM_STAGES-1] ? '0 : COMP_W'(qv[NUM_STAGES-1][2]);

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline not empty after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_unit) && $stable(zero_length))
    else $error("stalled result changed");
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (zr[1] == (s[1] == '0)))
    else $error("zero flag disagrees with sum");
  a_fill_accept: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready)
    else $error("input blocked with free first stage");
endmodule
`default_nettype wire

// ----- bench/tb_rgb_vector_normalizer_unit.sv -----
// Testbench for rgb_vector_normalizer_unit: random and directed RGB vectors, with words
// checked against a built-in unit-length predictor. Depends on rvn_pkg and the unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_vector_normalizer_unit;
  import rvn_pkg::*;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
    logic  zero;
  } unit_vec_t;

  class unit_scoreboard;
    unit_vec_t expected_q[$];

    // largest q with q*q*sum <= v*v*2^(2*OUT_FRACTION_BITS)
    function comp_t unit_component(logic [15:0] v, logic [63:0] sum);
      logic [127:0] target;
      logic [127:0] prod;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      target = (128'(v) * 128'(v)) << (2 * OUT_FRACTION_BITS);
      lo = 0;
      hi = 64'd1 << OUT_FRACTION_BITS;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        prod = 128'(mid) * 128'(mid) * 128'(sum);
        if (prod <= target) lo = mid;
        else hi = mid - 1;
      end
      if (lo > 64'hFFFF) lo = 64'hFFFF;
      return comp_t'(lo);
    endfunction

    function void note_input(comp_t r, comp_t g, comp_t b);
      logic [63:0] sum;
      unit_vec_t e;
      sum = 64'(r) * 64'(r) + 64'(g) * 64'(g) + 64'(b) * 64'(b);
      if (sum == 0) begin
        e = '{red: '0, green: '0, blue: '0, zero: 1'b1};
      end else begin
        e.red = unit_component(r, sum);
        e.green = unit_component(g, sum);
        e.blue = unit_component(b, sum);
        e.zero = 1'b0;
      end
      expected_q.push_back(e);
    endfunction

    function bit check(output unit_vec_t e);
      if (expected_q.size() == 0) return 1'b0;
      e = expected_q.pop_front();
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  comp_t red_in;
  comp_t green_in;
  comp_t blue_in;
  logic out_valid;
  logic out_ready;
  comp_t red_unit;
  comp_t green_unit;
  comp_t blue_unit;
  logic zero_length;

  unit_scoreboard sb;
  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;

  rgb_vector_normalizer_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_unit(red_unit), .green_unit(green_unit), .blue_unit(blue_unit),
    .zero_length(zero_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL rgb_vector_normalizer_unit");
    $finish;
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // sample result words on the falling edge before the accepting edge
  always @(negedge clk) begin
    unit_vec_t e;
    if (!rst && out_valid && out_ready) begin
      if (!sb.check(e)) begin
        report("unexpected word", 0, 0);
      end else begin
        if (red_unit !== e.red) report("red_unit", red_unit, e.red);
        if (green_unit !== e.green) report("green_unit", green_unit, e.green);
        if (blue_unit !== e.blue) report("blue_unit", blue_unit, e.blue);
        if (zero_length !== e.zero) report("zero_length", zero_length, e.zero);
      end
    end
  end

  task automatic send_word(comp_t r, comp_t g, comp_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_input(r, g, b);
  endtask

  function automatic comp_t pick_comp(int mode);
    case (mode)
      0: return comp_t'($urandom_range(15));
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2: return comp_t'(16'hFFFF - $urandom_range(15));
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic send_random();
    int kind;
    int mode;
    comp_t c;
    kind = $urandom_range(19);
    mode = $urandom_range(4);
    if (kind == 0) begin
      send_word('0, '0, '0);
    end else if (kind < 3) begin
      c = comp_t'($urandom_range(65535, 1));
      case ($urandom_range(2))
        0: send_word(c, '0, '0);
        1: send_word('0, c, '0);
        default: send_word('0, '0, c);
      endcase
    end else begin
      send_word(pick_comp(mode), pick_comp(mode), pick_comp(mode));
    end
  endtask

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_random();
  endtask

  initial begin
    int waited;
    sb = new();
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word('0, '0, '0);
    send_word(16'hFFFF, '0, '0);
    send_word('0, 16'hFFFF, '0);
    send_word('0, '0, 16'hFFFF);
    send_word(16'h0001, '0, '0);
    send_word('0, 16'h0001, '0);
    send_word('0, '0, 16'h0001);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h0001, 16'h0001, 16'h0001);
    send_word(16'hFFFF, 16'h0001, '0);
    send_word('0, 16'hFFFF, 16'h0001);
    send_word(16'h0001, '0, 16'hFFFF);
    send_word(16'h1000, 16'h1000, 16'h1000);
    send_word(16'h3000, 16'h4000, '0);
    send_word(16'h8000, 16'h7FFF, 16'h5555);
    send_word(16'hAAAA, 16'h5555, 16'hFFFE);
    send_word(16'h0002, 16'h0003, 16'h0006);

    run_phase(0, 0, 450);
    run_phase(70, 0, 350);
    run_phase(0, 70, 350);
    run_phase(70, 70, 200);
    run_phase(0, 9, 300);
    hold_req = 1'b1;
    run_phase(0, 0, 200);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && sb.pending() == 0) begin
      $display("PASS rgb_vector_normalizer_unit");
    end else begin
      $display("FAIL rgb_vector_normalizer_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
